FILE: rtl/kxs_pkg.sv
package kxs_pkg;

  localparam int KEY_BYTES = 32;
  localparam int RES_W     = $clog2(KEY_BYTES);
  localparam int ZERO_DIV  = 12;
  localparam int CFG_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int IDX_W     = $clog2(CFG_REGS);
  localparam int BYTE_OFS  = $clog2(REG_W / 8);
  localparam int ADDR_W    = IDX_W + BYTE_OFS;
  localparam int KEY_WORDS = CFG_REGS / 2;

  typedef logic [KEY_BYTES-1:0][7:0] key_t;
  typedef logic [RES_W-1:0]          res_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [REG_W-1:0]          word_t;

  function automatic int divisor_of(int k);
    return (k == 0) ? ZERO_DIV : k;
  endfunction

  function automatic logic [7:0] fold_key(key_t key);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      acc = acc ^ key[i];
    end
    return acc;
  endfunction

endpackage

FILE: rtl/kxs_cell.sv
module kxs_cell #(
  parameter int DIVISOR = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          last_i,
  input  kxs_pkg::key_t key_a_i,
  output logic [7:0]    term_o
);
  import kxs_pkg::*;

  localparam res_t LastRes = res_t'(DIVISOR - 1);

  res_t       res_q, res_d;
  logic [7:0] term_q;

  always_comb begin
    res_d = res_q;
    if (accept_i) begin
      if (last_i || (res_q >= LastRes)) begin
        res_d = '0;
      end else begin
        res_d = res_q + res_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      term_q <= key_a_i[res_q];
    end
  end

  assign term_o = term_q;

endmodule

FILE: rtl/kxs_regs.sv
module kxs_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  kxs_pkg::addr_t paddr,
  input  kxs_pkg::word_t pwdata,
  output kxs_pkg::word_t prdata,
  output kxs_pkg::key_t key_a_o,
  output kxs_pkg::key_t key_b_o
);
  import kxs_pkg::*;

  word_t             words_q [CFG_REGS];
  logic [IDX_W-1:0]  idx;

  assign idx = paddr[ADDR_W-1:BYTE_OFS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        words_q[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      words_q[idx] <= pwdata;
    end
  end

  assign prdata = words_q[idx];

  always_comb begin
    for (int w = 0; w < KEY_WORDS; w++) begin
      for (int b = 0; b < REG_W / 8; b++) begin
        key_a_o[w*(REG_W/8)+b] = words_q[w][8*b +: 8];
        key_b_o[w*(REG_W/8)+b] = words_q[w+KEY_WORDS][8*b +: 8];
      end
    end
  end

endmodule

FILE: rtl/keyed_xor_byte_scrambler_unit.sv
// An accepted item is captured in the first-stage registers, then loaded into the
// output register when the output is not stalled. Throughput: one item per cycle
// unless the output stalls; one residue cell per key A term captures its key byte
// at accept, and a registered XOR tree merges the terms in the next stage.
// Reset clears the position counter, all residue cells, both key registers and
// the pipeline valid flags; the block is ready in the first cycle after reset.
module keyed_xor_byte_scrambler_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  kxs_pkg::addr_t paddr,
  input  kxs_pkg::word_t pwdata,
  output kxs_pkg::word_t prdata,
  output logic           pready,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     data_byte_i,
  input  logic           last_in_buffer_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import kxs_pkg::*;

  key_t       key_a, key_b;
  logic [7:0] terms [KEY_BYTES];
  logic [7:0] term_sum;
  logic       accept, adv1, adv2;

  logic [7:0] pos_low_q, pos_low_d;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_data_q, s1_base_q;
  logic       s1_last_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  res_t       b_idx;

  kxs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .key_a_o (key_a),
    .key_b_o (key_b)
  );

  assign pready = 1'b1;

  assign adv2       = !out_valid_q || !out_stall_i;
  assign adv1       = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  for (genvar k = 0; k < KEY_BYTES; k++) begin : g_cell
    kxs_cell #(
      .DIVISOR (divisor_of(k))
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .last_i   (last_in_buffer_i),
      .key_a_i  (key_a),
      .term_o   (terms[k])
    );
  end

  always_comb begin
    term_sum = '0;
    for (int k = 0; k < KEY_BYTES; k++) begin
      term_sum = term_sum ^ terms[k];
    end
  end

  assign b_idx = res_t'(pos_low_q + 8'd1);

  always_comb begin
    pos_low_d = pos_low_q;
    if (accept) begin
      pos_low_d = last_in_buffer_i ? 8'd0 : pos_low_q + 8'd1;
    end
    s1_valid_d  = adv1 ? in_valid_i : s1_valid_q;
    out_valid_d = adv2 ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_low_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_low_q   <= pos_low_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_in_buffer_i;
      s1_base_q <= key_b[b_idx] ^ pos_low_q ^ fold_key(key_a) ^ fold_key(key_b);
    end
    if (s1_valid_q && adv2) begin
      out_byte_q <= s1_data_q ^ s1_base_q ^ term_sum;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  a_last_clears_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_in_buffer_i) |=> (pos_low_q == 8'd0))
    else $error("position not cleared after last item");

  a_pos_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !last_in_buffer_i) |=> (pos_low_q == $past(pos_low_q) + 8'd1))
    else $error("position did not advance by one");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled while first stage is empty");

  a_pos_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(pos_low_q))
    else $error("position changed without an accepted item");

endmodule
